### rtl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared constants, register map, handshake structs and the arctangent table
// of the sensor feature extractor.
// ----------------------------------------------------------------------------
package sfe_pkg;

  // sample width of the soil and rain converters
  localparam int unsigned SfeAdcBits   = 12;
  // vectoring iterations of the tilt engine (at most AtanEntries)
  localparam int unsigned CordicSteps  = 16;
  localparam int unsigned AtanEntries  = 24;

  // restoring divider: one quotient bit per cycle
  localparam int unsigned DivSteps     = SfeAdcBits + 17;
  localparam int unsigned DivCntW      = $clog2(DivSteps + 1);

  // configuration port
  localparam int unsigned CfgAddrW     = 5;
  localparam logic [2:0]  RegSoilDry   = 3'd0;
  localparam logic [2:0]  RegSoilWet   = 3'd1;
  localparam logic [2:0]  RegMoistLo   = 3'd2;
  localparam logic [2:0]  RegMoistHi   = 3'd3;
  localparam logic [2:0]  RegRainDry   = 3'd4;
  localparam logic [2:0]  RegRainWet   = 3'd5;
  localparam logic [2:0]  RegRainFull  = 3'd6;

  // fallbacks and limits
  localparam logic [15:0]        SoilFallback = 16'd15899;
  localparam logic [12:0]        TiltFallback = 13'd261;
  localparam logic signed [13:0] TempFallback = 14'sd2251;
  localparam logic [13:0]        HumFallback  = 14'd6435;
  localparam logic [15:0]        RainFallback = 16'd325;
  localparam logic [32:0]        MagSqMin     = 33'd6978;
  localparam logic [12:0]        TiltLow      = 13'd100;
  localparam logic [12:0]        TiltHigh     = 13'd4500;
  localparam logic [15:0]        VibMax       = 16'd10000;

  // floor(n / 1000) as (n * RecipM) >> RecipShift for n below 2^25
  localparam logic [25:0]        RecipM       = 26'd34359739;
  localparam int unsigned        RecipShift   = 35;
  localparam logic [24:0]        RoundHalf    = 25'd500;

  // request to the tilt engine
  typedef struct packed {
    logic        start;
    logic [29:0] mag_sq;
    logic [14:0] az;
  } tilt_req_t;

  // answer of the tilt engine, done stays high until the next start
  typedef struct packed {
    logic        done;
    logic [12:0] angle;
  } tilt_rsp_t;

  // atan(2^-i) in units of 1e-5 degree
  function automatic logic [22:0] atan_lut(input logic [4:0] idx);
    logic [22:0] v;
    unique case (idx)
      5'd0:    v = 23'd4500000;
      5'd1:    v = 23'd2656505;
      5'd2:    v = 23'd1403624;
      5'd3:    v = 23'd712502;
      5'd4:    v = 23'd357633;
      5'd5:    v = 23'd178991;
      5'd6:    v = 23'd89517;
      5'd7:    v = 23'd44761;
      5'd8:    v = 23'd22381;
      5'd9:    v = 23'd11191;
      5'd10:   v = 23'd5595;
      5'd11:   v = 23'd2798;
      5'd12:   v = 23'd1399;
      5'd13:   v = 23'd699;
      5'd14:   v = 23'd350;
      5'd15:   v = 23'd175;
      5'd16:   v = 23'd87;
      5'd17:   v = 23'd44;
      5'd18:   v = 23'd22;
      5'd19:   v = 23'd11;
      5'd20:   v = 23'd5;
      5'd21:   v = 23'd3;
      5'd22:   v = 23'd1;
      5'd23:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/sfe_if.sv
// ----------------------------------------------------------------------------
// sfe_in_if / sfe_out_if
// Valid/ready channels carrying one raw sensor record and one feature set.
// ----------------------------------------------------------------------------
interface sfe_in_if import sfe_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SfeAdcBits-1:0] soil_reading;
  logic                  soil_valid;
  logic [SfeAdcBits-1:0] rain_reading;
  logic                  rain_valid;
  logic signed [15:0]    accel_x_raw;
  logic signed [15:0]    accel_y_raw;
  logic signed [15:0]    accel_z_raw;
  logic                  accel_valid;
  logic signed [13:0]    temp_in;
  logic [13:0]           humidity_in;
  logic                  climate_valid;
  logic [15:0]           vibration_in;

  modport source (output valid, soil_reading, soil_valid, rain_reading, rain_valid,
                  accel_x_raw, accel_y_raw, accel_z_raw, accel_valid, temp_in,
                  humidity_in, climate_valid, vibration_in, input ready);
  modport sink   (input valid, soil_reading, soil_valid, rain_reading, rain_valid,
                  accel_x_raw, accel_y_raw, accel_z_raw, accel_valid, temp_in,
                  humidity_in, climate_valid, vibration_in, output ready);
endinterface

interface sfe_out_if import sfe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [15:0]        soil_vwc;
  logic signed [16:0] soil_change;
  logic [12:0]        tilt_angle;
  logic signed [13:0] tilt_change;
  logic [13:0]        vibration_out;
  logic signed [13:0] temp_out;
  logic [13:0]        humidity_out;
  logic [15:0]        rainfall_out;

  modport source (output valid, soil_vwc, soil_change, tilt_angle, tilt_change,
                  vibration_out, temp_out, humidity_out, rainfall_out, input ready);
  modport sink   (input valid, soil_vwc, soil_change, tilt_angle, tilt_change,
                  vibration_out, temp_out, humidity_out, rainfall_out, output ready);
endinterface

### rtl/sensor_feature_extractor_unit.sv
// ----------------------------------------------------------------------------
// sensor_feature_extractor_unit
// Turns one raw sensor record into eight fixed-point features.
// ----------------------------------------------------------------------------
// Usage:
//  - in_i takes one record per beat (valid/ready); out_o gives one feature
//    set per record, in order. The user must write registers over the APB
//    port only while the block is idle (unchecked); pready is always high.
//  - in_i.ready is high only while no record is at work. How long a
//    record takes from accept to out_o.valid depends on whether the maps
//    are trivial, invalid or divide and on whether the tilt rotation is
//    needed; in_i.ready rises again together with out_o.valid. The two
//    linear maps run one after the other on a shared 17x17 multiplier and
//    a restoring divider that gives one quotient bit per cycle. The tilt
//    engine (square root, then rotation) runs beside the maps.
//  - the result sits in an output register; the next record is accepted
//    while it waits. A later result waits in the sequencer until out_o
//    takes the earlier one.
//  - reset sets the registers to their defaults and the previous soil and
//    tilt values to zero; the block is ready right after reset.
// ----------------------------------------------------------------------------
module sensor_feature_extractor_unit import sfe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  sfe_in_if.sink              in_i,
  sfe_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_TCHK  = 4'd2;
  localparam logic [3:0] S_MSET  = 4'd3;
  localparam logic [3:0] S_MMUL  = 4'd4;
  localparam logic [3:0] S_MABS  = 4'd5;
  localparam logic [3:0] S_MDIV  = 4'd6;
  localparam logic [3:0] S_TWAIT = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam int unsigned AW = SfeAdcBits;

  // configuration registers
  logic [AW-1:0] soil_dry_q, soil_wet_q, rain_dry_q, rain_wet_q;
  logic [15:0]   moist_lo_q, moist_hi_q, rain_full_q;
  logic [2:0]    reg_idx;

  assign reg_idx = paddr[CfgAddrW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soil_dry_q  <= AW'(3000);
      soil_wet_q  <= AW'(1200);
      moist_lo_q  <= 16'd3277;
      moist_hi_q  <= 16'd32768;
      rain_dry_q  <= AW'(4095);
      rain_wet_q  <= AW'(1000);
      rain_full_q <= 16'd10000;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegSoilDry:  soil_dry_q  <= pwdata[AW-1:0];
        RegSoilWet:  soil_wet_q  <= pwdata[AW-1:0];
        RegMoistLo:  moist_lo_q  <= pwdata[15:0];
        RegMoistHi:  moist_hi_q  <= pwdata[15:0];
        RegRainDry:  rain_dry_q  <= pwdata[AW-1:0];
        RegRainWet:  rain_wet_q  <= pwdata[AW-1:0];
        RegRainFull: rain_full_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      RegSoilDry:  prdata = 32'(soil_dry_q);
      RegSoilWet:  prdata = 32'(soil_wet_q);
      RegMoistLo:  prdata = 32'(moist_lo_q);
      RegMoistHi:  prdata = 32'(moist_hi_q);
      RegRainDry:  prdata = 32'(rain_dry_q);
      RegRainWet:  prdata = 32'(rain_wet_q);
      RegRainFull: prdata = 32'(rain_full_q);
      default:     prdata = '0;
    endcase
  end

  // sequencer and work registers
  logic [3:0]          state_q, state_d;
  logic [DivCntW-1:0]  cnt_q;
  logic                map_sel_q, tilt_pend_q, out_valid_q;
  logic [15:0]         last_vwc_q;
  logic [12:0]         last_tilt_q;

  logic [AW-1:0]       soil_rd_q, rain_rd_q;
  logic                soil_ok_q, rain_ok_q, acc_ok_q, clim_ok_q;
  logic signed [15:0]  ax_q, ay_q, az_q;
  logic signed [13:0]  temp_q;
  logic [13:0]         hum_q;
  logic [15:0]         vib_q;
  logic [31:0]         s_q, azsq_q;
  logic signed [AW:0]  num_q, den_q;
  logic signed [33:0]  prod_q;
  logic                pneg_q;
  logic [DivSteps-1:0] dvd_q;
  logic [AW-1:0]       rem_q;
  logic [15:0]         vwc_q, rain_q;
  logic [12:0]         tilt_q;

  // output register
  logic [15:0]         o_vwc_q, o_rain_q;
  logic signed [16:0]  o_soil_chg_q;
  logic [12:0]         o_tilt_q;
  logic signed [13:0]  o_tilt_chg_q, o_temp_q;
  logic [13:0]         o_vib_q, o_hum_q;

  tilt_req_t           tilt_req;
  tilt_rsp_t           tilt_rsp;

  // map operands of the map at work
  logic [AW-1:0]       m_dry, m_wet, m_x;
  logic [15:0]         m_out0, m_out1, m_fallback;
  logic                m_ok;
  logic signed [AW:0]  den0, num0;

  always_comb begin
    if (!map_sel_q) begin
      m_dry = soil_dry_q;  m_wet = soil_wet_q;  m_x = soil_rd_q;
      m_out0 = moist_lo_q; m_out1 = moist_hi_q;
      m_ok = soil_ok_q;    m_fallback = SoilFallback;
    end else begin
      m_dry = rain_dry_q;  m_wet = rain_wet_q;  m_x = rain_rd_q;
      m_out0 = 16'd0;      m_out1 = rain_full_q;
      m_ok = rain_ok_q;    m_fallback = RainFallback;
    end
    den0 = $signed({1'b0, m_dry}) - $signed({1'b0, m_wet});
    num0 = $signed({1'b0, m_dry}) - $signed({1'b0, m_x});
  end

  // shared multiplier: squares, then the map product
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;

  always_comb begin
    priority case (1'b1)
      (state_q == S_SQ) && (cnt_q == DivCntW'(0)): mul_a = 17'(ax_q);
      (state_q == S_SQ) && (cnt_q == DivCntW'(1)): mul_a = 17'(ay_q);
      (state_q == S_SQ):                           mul_a = 17'(az_q);
      default:                                     mul_a = 17'(num_q);
    endcase
    if (state_q == S_SQ) begin
      mul_b = mul_a;
    end else begin
      mul_b = $signed({1'b0, m_out1}) - $signed({1'b0, m_out0});
    end
    mul_p = mul_a * mul_b;
  end

  // divider step and map result
  logic [AW+1:0]       div_tr;
  logic                qbit;
  logic [DivSteps-1:0] q_full;
  logic [16:0]         q_ext, map_res;
  logic                map_last;

  always_comb begin
    div_tr   = {1'b0, rem_q, dvd_q[DivSteps-1]} - {2'b00, den_q[AW-1:0]};
    qbit     = !div_tr[AW+1];
    q_full   = {dvd_q[DivSteps-2:0], qbit};
    q_ext    = {1'b0, q_full[15:0]};
    map_res  = {1'b0, m_out0} + (pneg_q ? -q_ext : q_ext);
    map_last = (cnt_q == DivCntW'(DivSteps - 1));
  end

  logic [32:0] mag_sum;
  logic        out_free;

  assign mag_sum  = {1'b0, s_q} + {1'b0, azsq_q};
  assign out_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_i.valid) state_d = S_SQ;
      S_SQ:    if (cnt_q == DivCntW'(2)) state_d = S_TCHK;
      S_TCHK:  state_d = S_MSET;
      S_MSET:  state_d = m_ok ? S_MMUL : (map_sel_q ? S_TWAIT : S_MSET);
      S_MMUL: begin
        if (den_q == '0 || num_q <= 0 || num_q >= den_q) begin
          state_d = map_sel_q ? S_TWAIT : S_MSET;
        end else begin
          state_d = S_MABS;
        end
      end
      S_MABS:  state_d = S_MDIV;
      S_MDIV:  if (map_last) state_d = map_sel_q ? S_TWAIT : S_MSET;
      S_TWAIT: if (!tilt_pend_q || tilt_rsp.done) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // tilt engine request
  always_comb begin
    tilt_req.start  = (state_q == S_TCHK) && acc_ok_q && (mag_sum > MagSqMin) &&
                      !(az_q <= 0) && (s_q < azsq_q);
    tilt_req.mag_sq = s_q[29:0];
    tilt_req.az     = az_q[14:0];
  end

  sfe_tilt u_tilt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tilt_req),
    .rsp_o  (tilt_rsp)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      map_sel_q   <= 1'b0;
      tilt_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      last_vwc_q  <= '0;
      last_tilt_q <= '0;
    end else begin
      state_q <= state_d;
      // result beat: set on load, cleared when taken
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          cnt_q     <= '0;
          map_sel_q <= 1'b0;
        end
        S_SQ:   cnt_q <= (cnt_q == DivCntW'(2)) ? '0 : cnt_q + DivCntW'(1);
        S_TCHK: tilt_pend_q <= tilt_req.start;
        S_MSET: if (!m_ok) map_sel_q <= 1'b1;
        S_MMUL: begin
          cnt_q <= '0;
          if (state_d != S_MABS) map_sel_q <= 1'b1;
        end
        S_MDIV: begin
          cnt_q <= cnt_q + DivCntW'(1);
          if (map_last) map_sel_q <= 1'b1;
        end
        S_DONE: begin
          if (out_free) begin
            last_vwc_q  <= vwc_q;
            last_tilt_q <= tilt_q;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          soil_rd_q <= in_i.soil_reading;
          soil_ok_q <= in_i.soil_valid;
          rain_rd_q <= in_i.rain_reading;
          rain_ok_q <= in_i.rain_valid;
          ax_q      <= in_i.accel_x_raw;
          ay_q      <= in_i.accel_y_raw;
          az_q      <= in_i.accel_z_raw;
          acc_ok_q  <= in_i.accel_valid;
          temp_q    <= in_i.temp_in;
          hum_q     <= in_i.humidity_in;
          clim_ok_q <= in_i.climate_valid;
          vib_q     <= in_i.vibration_in;
        end
      end
      S_SQ: begin
        if (cnt_q == DivCntW'(0)) begin
          s_q <= mul_p[31:0];
        end else if (cnt_q == DivCntW'(1)) begin
          s_q <= s_q + mul_p[31:0];
        end else begin
          azsq_q <= mul_p[31:0];
        end
      end
      S_TCHK: begin
        if (!acc_ok_q || mag_sum <= MagSqMin) begin
          tilt_q <= TiltFallback;
        end else if (az_q <= 0 || s_q >= azsq_q) begin
          tilt_q <= TiltHigh;
        end
      end
      S_MSET: begin
        if (!m_ok) begin
          if (!map_sel_q) vwc_q <= m_fallback;
          else rain_q <= m_fallback;
        end
        if (den0 < 0) begin
          den_q <= -den0;
          num_q <= -num0;
        end else begin
          den_q <= den0;
          num_q <= num0;
        end
      end
      S_MMUL: begin
        prod_q <= mul_p;
        if (den_q == '0 || num_q <= 0) begin
          if (!map_sel_q) vwc_q <= m_out0;
          else rain_q <= m_out0;
        end else if (num_q >= den_q) begin
          if (!map_sel_q) vwc_q <= m_out1;
          else rain_q <= m_out1;
        end
      end
      S_MABS: begin
        pneg_q <= prod_q[33];
        dvd_q  <= DivSteps'(prod_q[33] ? -prod_q : prod_q) +
                  DivSteps'(den_q[AW:1]);
        rem_q  <= '0;
      end
      S_MDIV: begin
        dvd_q <= q_full;
        if (qbit) rem_q <= div_tr[AW-1:0];
        else rem_q <= {rem_q[AW-2:0], dvd_q[DivSteps-1]};
        if (map_last) begin
          if (!map_sel_q) vwc_q <= map_res[15:0];
          else rain_q <= map_res[15:0];
        end
      end
      S_TWAIT: if (tilt_pend_q) tilt_q <= tilt_rsp.angle;
      S_DONE: begin
        if (out_free) begin
          o_vwc_q      <= vwc_q;
          o_soil_chg_q <= $signed({1'b0, vwc_q}) - $signed({1'b0, last_vwc_q});
          o_tilt_q     <= tilt_q;
          o_tilt_chg_q <= $signed({1'b0, tilt_q}) - $signed({1'b0, last_tilt_q});
          o_vib_q      <= (vib_q > VibMax) ? VibMax[13:0] : vib_q[13:0];
          o_temp_q     <= clim_ok_q ? temp_q : TempFallback;
          o_hum_q      <= clim_ok_q ? hum_q : HumFallback;
          o_rain_q     <= rain_q;
        end
      end
      default: ;
    endcase
  end

  // channel outputs
  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.soil_vwc      = o_vwc_q;
  assign out_o.soil_change   = o_soil_chg_q;
  assign out_o.tilt_angle    = o_tilt_q;
  assign out_o.tilt_change   = o_tilt_chg_q;
  assign out_o.vibration_out = o_vib_q;
  assign out_o.temp_out      = o_temp_q;
  assign out_o.humidity_out  = o_hum_q;
  assign out_o.rainfall_out  = o_rain_q;

endmodule

### rtl/sfe_tilt.sv
// ----------------------------------------------------------------------------
// sfe_tilt
// Iterative tilt engine: bit-pair square root, vectoring rotation with
// barrel shifters on x and y, then rounding to centidegrees and clamping.
// ----------------------------------------------------------------------------
module sfe_tilt import sfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tilt_req_t req_i,
  output tilt_rsp_t rsp_o
);

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_SQRT = 3'd1;
  localparam logic [2:0] T_CORD = 3'd2;
  localparam logic [2:0] T_RND1 = 3'd3;
  localparam logic [2:0] T_RND2 = 3'd4;

  logic [2:0]         phase_q;
  logic [4:0]         step_q;
  logic               done_q;
  logic [12:0]        angle_q;
  logic [63:0]        rad_q;
  logic [32:0]        rem_q;
  logic [31:0]        root_q;
  logic signed [33:0] x_q, y_q;
  logic signed [24:0] z_q;
  logic [50:0]        prod_q;

  logic [34:0]        rem_sh, trial;
  logic [32:0]        rem_nx;
  logic [31:0]        root_nx;
  logic signed [33:0] x_sh, y_sh;
  logic signed [24:0] atan_v;
  logic [24:0]        rnd_n;
  logic [15:0]        cd;

  // square root digit step
  always_comb begin
    rem_sh = {rem_q, rad_q[63:62]};
    trial  = {1'b0, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_nx  = 33'(rem_sh - trial);
      root_nx = {root_q[30:0], 1'b1};
    end else begin
      rem_nx  = rem_sh[32:0];
      root_nx = {root_q[30:0], 1'b0};
    end
  end

  // rotation operands and rounding
  always_comb begin
    x_sh   = x_q >>> step_q;
    y_sh   = y_q >>> step_q;
    atan_v = $signed({2'b00, atan_lut(step_q)});
    rnd_n  = z_q[24] ? 25'd0 : 25'(z_q) + RoundHalf;
    cd     = prod_q[50:RecipShift];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= T_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      unique case (phase_q)
        T_IDLE: begin
          if (req_i.start) begin
            done_q  <= 1'b0;
            step_q  <= '0;
            phase_q <= T_SQRT;
          end
        end
        T_SQRT: begin
          if (step_q == 5'd31) begin
            step_q  <= '0;
            phase_q <= T_CORD;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        T_CORD: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'(CordicSteps - 1)) begin
            phase_q <= T_RND1;
          end
        end
        T_RND1: phase_q <= T_RND2;
        T_RND2: begin
          done_q  <= 1'b1;
          phase_q <= T_IDLE;
        end
        default: phase_q <= T_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      T_IDLE: begin
        rad_q  <= {2'b00, req_i.mag_sq, 32'd0};
        rem_q  <= '0;
        root_q <= '0;
        x_q    <= $signed({3'b000, req_i.az, 16'd0});
        z_q    <= '0;
      end
      T_SQRT: begin
        rad_q  <= {rad_q[61:0], 2'b00};
        rem_q  <= rem_nx;
        root_q <= root_nx;
        y_q    <= $signed({2'b00, root_nx});
      end
      T_CORD: begin
        if (!y_q[33]) begin
          x_q <= x_q + y_sh;
          y_q <= y_q - x_sh;
          z_q <= z_q + atan_v;
        end else begin
          x_q <= x_q - y_sh;
          y_q <= y_q + x_sh;
          z_q <= z_q - atan_v;
        end
      end
      T_RND1: prod_q <= 51'(rnd_n) * 51'(RecipM);
      T_RND2: begin
        if (cd < 16'(TiltLow)) begin
          angle_q <= TiltLow;
        end else if (cd > 16'(TiltHigh)) begin
          angle_q <= TiltHigh;
        end else begin
          angle_q <= cd[12:0];
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = angle_q;

endmodule

### rtl/sfe_checker.sv
// ----------------------------------------------------------------------------
// sfe_checker
// Port-level checks of the sensor feature extractor, bound to the top level.
// ----------------------------------------------------------------------------
module sfe_checker import sfe_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [12:0] tilt_angle,
  input logic [13:0] vibration_out
);

  // a stalled result beat holds its valid and its tilt angle
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(tilt_angle))
    else $error("stalled result beat changed");

  // one record at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a record is at work");

  // tilt inside its clamp range whenever a result is valid
  a_tilt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> tilt_angle >= TiltLow && tilt_angle <= TiltHigh)
    else $error("tilt outside clamp range");

  // vibration clamped
  a_vib_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> vibration_out <= VibMax[13:0])
    else $error("vibration above limit");

endmodule

bind sensor_feature_extractor_unit sfe_checker u_sfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .tilt_angle    (out_o.tilt_angle),
  .vibration_out (out_o.vibration_out)
);
